// ----- rtl/toy_spn_pkg.sv -----
// ============================================================================
// toy_spn_pkg
// Shared types, constants and table functions of the 8-bit SPN CBC cipher.
// ============================================================================
`default_nettype none

package toy_spn_pkg;

    // Number of cipher rounds (1 to 14).
    localparam int ROUNDS     = 4;

    // Field and register widths.
    localparam int BLOCK_W    = 8;
    localparam int KEY_W      = 24;
    localparam int SBOX_W     = 64;
    localparam int PBOX_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // The key string is zero-extended on the right to this width, so that
    // any round key offset up to 4 * 14 stays inside it.
    localparam int KEY_EXT_W  = 64;

    // Reset values of the configuration registers.
    localparam logic [KEY_W-1:0]   KEY_RESET  = '0;
    localparam logic [SBOX_W-1:0]  SBOX_RESET = 64'h0123_4567_89AB_CDEF;
    localparam logic [PBOX_W-1:0]  PBOX_RESET = 24'h05_3977;
    localparam logic [BLOCK_W-1:0] IV_RESET   = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY  = 3'd0,
        CFG_SBOX = 3'd1,
        CFG_PBOX = 3'd2,
        CFG_IV   = 3'd3,
        CFG_DIR  = 3'd4
    } cfg_index_t;

    // Configuration as seen by the datapath, with the inverse tables.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SBOX_W-1:0]  sbox;
        logic [SBOX_W-1:0]  sbox_inv;
        logic [PBOX_W-1:0]  pbox;
        logic [PBOX_W-1:0]  pbox_inv;
        logic [BLOCK_W-1:0] iv;
        logic               decrypt;
    } cfg_t;

    // Eight key bits starting at the given offset of the key string.
    // Key bit 0 is the top bit of the key register.
    function automatic logic [BLOCK_W-1:0] round_key(logic [KEY_W-1:0] key, int offset);
        logic [KEY_EXT_W-1:0] ext;
        ext = {key, {(KEY_EXT_W-KEY_W){1'b0}}};
        return ext[KEY_EXT_W-1-offset -: BLOCK_W];
    endfunction

    // Both nibbles through the S-box; entry 0 sits in the top nibble.
    function automatic logic [BLOCK_W-1:0] sbox_apply(logic [BLOCK_W-1:0] x,
                                                     logic [SBOX_W-1:0] tbl);
        return {tbl[{~x[7:4], 2'b00} +: 4], tbl[{~x[3:0], 2'b00} +: 4]};
    endfunction

    // Bit permutation: output bit i from the MSB takes input bit entry[i].
    function automatic logic [BLOCK_W-1:0] pbox_apply(logic [BLOCK_W-1:0] x,
                                                     logic [PBOX_W-1:0] tbl);
        logic [BLOCK_W-1:0] y;
        logic [2:0]         src;
        y = '0;
        for (int i = 0; i < 8; i++) begin
            src        = tbl[(7-i)*3 +: 3];
            y[7-i]     = x[~src];
        end
        return y;
    endfunction

    // Inverse S-box: the largest index that maps to a value wins, and a
    // value that nothing maps to gets entry zero.
    function automatic logic [SBOX_W-1:0] sbox_invert(logic [SBOX_W-1:0] tbl);
        logic [SBOX_W-1:0] inv;
        inv = '0;
        for (int v = 0; v < 16; v++) begin
            for (int i = 0; i < 16; i++) begin
                if (tbl[(15-i)*4 +: 4] == 4'(v)) begin
                    inv[(15-v)*4 +: 4] = 4'(i);
                end
            end
        end
        return inv;
    endfunction

    // Inverse P-box, with the same rule for repeated or missing sources.
    function automatic logic [PBOX_W-1:0] pbox_invert(logic [PBOX_W-1:0] tbl);
        logic [PBOX_W-1:0] inv;
        inv = '0;
        for (int v = 0; v < 8; v++) begin
            for (int i = 0; i < 8; i++) begin
                if (tbl[(7-i)*3 +: 3] == 3'(v)) begin
                    inv[(7-v)*3 +: 3] = 3'(i);
                end
            end
        end
        return inv;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/toy_spn_cfg.sv -----
// ============================================================================
// toy_spn_cfg
// Configuration registers; the inverse tables are formed as a table is written.
// ============================================================================
`default_nettype none

module toy_spn_cfg
    import toy_spn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [KEY_W-1:0]   key_reg;
    logic [SBOX_W-1:0]  sbox_reg;
    logic [SBOX_W-1:0]  sbox_inv_reg;
    logic [PBOX_W-1:0]  pbox_reg;
    logic [PBOX_W-1:0]  pbox_inv_reg;
    logic [BLOCK_W-1:0] iv_reg;
    logic               dir_reg;

    // Every write transaction is taken at once.
    assign cfg_ready = 1'b1;

    // Register file. Writes to indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg      <= KEY_RESET;
            sbox_reg     <= SBOX_RESET;
            sbox_inv_reg <= sbox_invert(SBOX_RESET);
            pbox_reg     <= PBOX_RESET;
            pbox_inv_reg <= pbox_invert(PBOX_RESET);
            iv_reg       <= IV_RESET;
            dir_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEY: begin
                    key_reg <= cfg_data[KEY_W-1:0];
                end
                CFG_SBOX: begin
                    sbox_reg     <= cfg_data[SBOX_W-1:0];
                    sbox_inv_reg <= sbox_invert(cfg_data[SBOX_W-1:0]);
                end
                CFG_PBOX: begin
                    pbox_reg     <= cfg_data[PBOX_W-1:0];
                    pbox_inv_reg <= pbox_invert(cfg_data[PBOX_W-1:0]);
                end
                CFG_IV: begin
                    iv_reg <= cfg_data[BLOCK_W-1:0];
                end
                CFG_DIR: begin
                    dir_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.key      = key_reg;
    assign cfg.sbox     = sbox_reg;
    assign cfg.sbox_inv = sbox_inv_reg;
    assign cfg.pbox     = pbox_reg;
    assign cfg.pbox_inv = pbox_inv_reg;
    assign cfg.iv       = iv_reg;
    assign cfg.decrypt  = dir_reg;

endmodule

`default_nettype wire

// ----- rtl/toy_spn_core.sv -----
// ============================================================================
// toy_spn_core
// Round datapath: all encryption and decryption rounds plus the CBC mixing.
// ============================================================================
`default_nettype none

module toy_spn_core
    import toy_spn_pkg::*;
(
    input  wire cfg_t                cfg,
    input  wire logic [BLOCK_W-1:0]  data_block,
    input  wire logic                first_block,
    input  wire logic [BLOCK_W-1:0]  chain_block,
    output logic [BLOCK_W-1:0]       result_block,
    output logic [BLOCK_W-1:0]       chain_next
);

    logic [BLOCK_W-1:0] prev_block;
    logic [BLOCK_W-1:0] enc_stage [0:ROUNDS];
    logic [BLOCK_W-1:0] dec_stage [0:ROUNDS];
    logic [BLOCK_W-1:0] enc_block;
    logic [BLOCK_W-1:0] dec_block;

    // Chain value: the IV for a first block, else the stored block.
    assign prev_block = first_block ? cfg.iv : chain_block;

    // Encryption rounds: key mix, S-box, then permutation but in the last round.
    assign enc_stage[0] = data_block ^ prev_block;
    for (genvar r = 1; r <= ROUNDS; r++) begin : g_enc
        logic [BLOCK_W-1:0] subst;
        assign subst = sbox_apply(enc_stage[r-1] ^ round_key(cfg.key, 4*(r-1)), cfg.sbox);
        if (r != ROUNDS) begin : g_perm
            assign enc_stage[r] = pbox_apply(subst, cfg.pbox);
        end else begin : g_last
            assign enc_stage[r] = subst;
        end
    end
    assign enc_block = enc_stage[ROUNDS] ^ round_key(cfg.key, 4*ROUNDS);

    // Decryption rounds in reverse order with the inverse tables.
    assign dec_stage[ROUNDS] = data_block ^ round_key(cfg.key, 4*ROUNDS);
    for (genvar r = ROUNDS; r >= 1; r--) begin : g_dec
        logic [BLOCK_W-1:0] unperm;
        if (r != ROUNDS) begin : g_perm
            assign unperm = pbox_apply(dec_stage[r], cfg.pbox_inv);
        end else begin : g_last
            assign unperm = dec_stage[r];
        end
        assign dec_stage[r-1] = sbox_apply(unperm, cfg.sbox_inv)
                              ^ round_key(cfg.key, 4*(r-1));
    end
    assign dec_block = dec_stage[0] ^ prev_block;

    // The chain always carries the ciphertext side of the transaction.
    assign result_block = cfg.decrypt ? dec_block  : enc_block;
    assign chain_next   = cfg.decrypt ? data_block : enc_block;

endmodule

`default_nettype wire

// ----- rtl/toy_spn_block_cipher_cbc.sv -----
// ============================================================================
// toy_spn_block_cipher_cbc
// 8-bit substitution-permutation block cipher in CBC mode, stream interface.
// ============================================================================
// The block takes one 8-bit block per clock unless the output stalls and
// returns one result per block, in order. An input register and a result
// register frame a single-pass round datapath; the CBC chain register is
// updated as each block moves into the result register. Key, S-box, P-box,
// IV and direction are written through the configuration channel; the user
// must write them only while the block is idle, which the block does not
// enforce. The inverse tables are built in the same write.
`default_nettype none

module toy_spn_block_cipher_cbc
    import toy_spn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // Input blocks.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_block
    input  wire logic                  s_tuser,   // [0] first_block

    // Result blocks.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata    // [7:0] result_block
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [BLOCK_W-1:0] in_data_reg;
    logic               in_first_reg;
    logic               out_valid_reg;
    logic [BLOCK_W-1:0] out_data_reg;
    logic [BLOCK_W-1:0] chain_reg;
    logic [BLOCK_W-1:0] result_block;
    logic [BLOCK_W-1:0] chain_next;
    logic               advance;

    toy_spn_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    toy_spn_core u_core (
        .cfg          (cfg),
        .data_block   (in_data_reg),
        .first_block  (in_first_reg),
        .chain_block  (chain_reg),
        .result_block (result_block),
        .chain_next   (chain_next)
    );

    // The pipeline moves whenever the result register is free or drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // Result register and chain register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= result_block;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/toy_spn_chk.sv -----
// ============================================================================
// toy_spn_chk
// Port-level checks of the cipher's stream behavior, bound to the top level.
// ============================================================================
`default_nettype none

module toy_spn_chk (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result is shown right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the result register empty the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output is empty");

    // An accepted block is followed by a valid result at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted block did not reach the output");

endmodule

bind toy_spn_block_cipher_cbc toy_spn_chk u_toy_spn_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

// ----- sim/toy_spn_cbc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_spn_cbc_checker
// Watches the configuration, input and result channels of the SPN CBC
// cipher. It keeps its own copy of the registers and of the chain block,
// works out the expected result of every accepted input block and compares
// each accepted result against the oldest expected one.
// ----------------------------------------------------------------------------

module toy_spn_cbc_checker
    import toy_spn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,

    output int                    mismatches,
    output int                    pending_blocks
);

    // Register copies, with the inverse tables derived on every table write.
    logic [KEY_W-1:0]   key_r;
    logic [3:0]         sbox_fwd [16];
    logic [3:0]         sbox_rev [16];
    logic [2:0]         perm_fwd [8];
    logic [2:0]         perm_rev [8];
    logic [BLOCK_W-1:0] iv_r;
    logic               decrypt_r;
    logic [BLOCK_W-1:0] chain_r;

    logic [BLOCK_W-1:0] expected_blocks [$];
    int                 err_total;
    int                 in_flight;

    assign mismatches     = err_total;
    assign pending_blocks = in_flight;

    task automatic report_mismatch(input string msg);
        err_total++;
        $display("%0t ns: MISMATCH: %s", $time, msg);
    endtask

    // The largest index mapping to a value wins; unmapped values invert to 0.
    task automatic load_sbox(input logic [SBOX_W-1:0] tbl);
        for (int i = 0; i < 16; i++) begin
            sbox_fwd[i] = tbl[60-4*i +: 4];
            sbox_rev[i] = '0;
        end
        for (int i = 0; i < 16; i++) begin
            sbox_rev[sbox_fwd[i]] = 4'(i);
        end
    endtask

    task automatic load_pbox(input logic [PBOX_W-1:0] tbl);
        for (int i = 0; i < 8; i++) begin
            perm_fwd[i] = tbl[21-3*i +: 3];
            perm_rev[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            perm_rev[perm_fwd[i]] = 3'(i);
        end
    endtask

    // Eight key bits from the given offset; key bit 0 is the register MSB
    // and bits past the register read as zero.
    function automatic logic [7:0] key_slice(int offset);
        logic [63:0] ext;
        ext = {key_r, 40'd0};
        return ext[63-offset -: 8];
    endfunction

    function automatic logic [7:0] substitute(logic [7:0] x, bit inverse);
        if (inverse) begin
            return {sbox_rev[x[7:4]], sbox_rev[x[3:0]]};
        end
        return {sbox_fwd[x[7:4]], sbox_fwd[x[3:0]]};
    endfunction

    // Output bit i from the MSB takes input bit src from the MSB.
    function automatic logic [7:0] permute(logic [7:0] x, bit inverse);
        logic [7:0] y;
        logic [2:0] src;
        y = '0;
        for (int i = 0; i < 8; i++) begin
            src      = inverse ? perm_rev[i] : perm_fwd[i];
            y[7-i]   = x[7-src];
        end
        return y;
    endfunction

    function automatic logic [7:0] encipher(logic [7:0] x);
        for (int r = 1; r <= ROUNDS; r++) begin
            x = substitute(x ^ key_slice(4*(r-1)), 1'b0);
            if (r != ROUNDS) begin
                x = permute(x, 1'b0);
            end
        end
        return x ^ key_slice(4*ROUNDS);
    endfunction

    function automatic logic [7:0] decipher(logic [7:0] x);
        x = x ^ key_slice(4*ROUNDS);
        for (int r = ROUNDS; r >= 1; r--) begin
            if (r != ROUNDS) begin
                x = permute(x, 1'b1);
            end
            x = substitute(x, 1'b1) ^ key_slice(4*(r-1));
        end
        return x;
    endfunction

    // CBC step: returns the expected result and advances the chain block.
    function automatic logic [7:0] cbc_result(logic [7:0] data, logic first);
        logic [7:0] prev;
        logic [7:0] res;
        prev = first ? iv_r : chain_r;
        if (!decrypt_r) begin
            res     = encipher(data ^ prev);
            chain_r = res;
        end else begin
            res     = decipher(data) ^ prev;
            chain_r = data;
        end
        return res;
    endfunction

    initial begin
        err_total = 0;
        in_flight = 0;
    end

    // All channels are sampled at the rising edge.
    always @(posedge aclk) begin : watch
        logic [7:0] want;
        if (!aresetn) begin
            key_r     = KEY_RESET;
            iv_r      = IV_RESET;
            decrypt_r = 1'b0;
            chain_r   = '0;
            load_sbox(SBOX_RESET);
            load_pbox(PBOX_RESET);
            expected_blocks.delete();
            in_flight = 0;
        end else begin
            // Configuration transaction; indexes past the list are ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_KEY:  key_r = cfg_data[KEY_W-1:0];
                    CFG_SBOX: load_sbox(cfg_data[SBOX_W-1:0]);
                    CFG_PBOX: load_pbox(cfg_data[PBOX_W-1:0]);
                    CFG_IV:   iv_r = cfg_data[BLOCK_W-1:0];
                    CFG_DIR:  decrypt_r = cfg_data[0];
                    default:  ;
                endcase
            end

            // Result transaction against the oldest expected block.
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("result_block %02h with no block pending",
                                              m_tdata));
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("result_block got %02h, expected %02h",
                                                  m_tdata, want));
                    end
                end
            end

            // Input transaction.
            if (s_tvalid && s_tready) begin
                expected_blocks.push_back(cbc_result(s_tdata, s_tuser));
            end
            in_flight = expected_blocks.size();
        end
    end

endmodule

// ----- sim/tb_toy_spn_block_cipher_cbc.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_toy_spn_block_cipher_cbc
// Drives the SPN CBC cipher through directed settings (table extremes,
// repeated S-box and P-box entries, both directions, IV and chain use) and
// then through random settings with CBC messages of random length, random
// gaps on the input side, random stalls on the result side and two long
// result hold-offs. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_toy_spn_block_cipher_cbc;
    import toy_spn_pkg::*;

    localparam int RANDOM_PHASES = 10;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;

    int mismatches;
    int pending_blocks;
    int hold_requests;
    int holds_done;
    bit steady_phase;

    toy_spn_block_cipher_cbc dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    toy_spn_cbc_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .pending_blocks (pending_blocks)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("toy_spn_block_cipher_cbc test failed");
        $finish;
    end

    // Random table with every entry used once; entry 0 lands in the top bits.
    function automatic logic [63:0] shuffled_table(int entries, int bits);
        int          order [16];
        int          j;
        int          t;
        logic [63:0] tbl_bits;
        for (int i = 0; i < entries; i++) begin
            order[i] = i;
        end
        for (int i = entries - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        tbl_bits = '0;
        for (int i = 0; i < entries; i++) begin
            tbl_bits = (tbl_bits << bits) | 64'(order[i]);
        end
        return tbl_bits;
    endfunction

    // One configuration transaction; valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Writes every register, optionally followed by an index past the list.
    task automatic configure(input logic [63:0] key, input logic [63:0] sbox,
                             input logic [63:0] pbox, input logic [63:0] iv,
                             input logic [63:0] dir, input bit unused_write);
        write_reg(CFG_KEY, key);
        write_reg(CFG_SBOX, sbox);
        write_reg(CFG_PBOX, pbox);
        write_reg(CFG_IV, iv);
        write_reg(CFG_DIR, dir);
        if (unused_write) begin
            write_reg(3'(CFG_DIR) + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
    endtask

    // One input transaction followed by a random gap, or none in a steady phase.
    task automatic send_block(input logic [7:0] data, input logic first);
        int gap;
        int pick;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pick = $urandom_range(0, 99);
        if (steady_phase || pick < 55) begin
            gap = 0;
        end else if (pick < 93) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering blocks and waits until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_blocks != 0) @(posedge aclk);
    endtask

    // Result side: random stalls and runs, plus a long hold-off on request.
    initial begin : receiver
        int pick;
        int stall;
        int run;
        holds_done = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else begin
                pick  = $urandom_range(0, 99);
                stall = 0;
                if (pick < 3) begin
                    stall = $urandom_range(30, 150);
                end else if (pick < 35) begin
                    stall = $urandom_range(1, 3);
                end
                run = (pick >= 90) ? $urandom_range(40, 120) : $urandom_range(1, 12);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int          items;
        int          msg_left;
        int          pick;
        logic [7:0]  data;
        logic        first;
        logic [63:0] sbox;
        logic [63:0] pbox;
        logic [63:0] key;

        hold_requests = 0;
        steady_phase  = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, encrypt; the first block chains from the reset chain.
        send_block(8'h3C, 1'b0);
        send_block(8'h00, 1'b1);
        send_block(8'hFF, 1'b0);
        send_block(8'hA5, 1'b0);
        drain();

        // All-ones key, reversed S-box and P-box, all-ones IV, encrypt.
        configure(64'hFFFFFF, 64'hFEDC_BA98_7654_3210, 64'hFAC688, 64'hFF, 64'h0, 1'b0);
        send_block(8'hFF, 1'b1);
        send_block(8'h00, 1'b0);
        send_block(8'h80, 1'b0);
        send_block(8'h01, 1'b0);
        drain();

        // Same tables, decrypt.
        configure(64'hFFFFFF, 64'hFEDC_BA98_7654_3210, 64'hFAC688, 64'hFF, 64'h1, 1'b0);
        send_block(8'hFF, 1'b1);
        send_block(8'h00, 1'b0);
        send_block(8'h7E, 1'b0);
        send_block(8'h81, 1'b1);
        drain();

        // Constant S-box and P-box with a single source, decrypt, plus a
        // write to an index outside the register list.
        configure(64'hA5C3F0, 64'h0, 64'h0, 64'h5A, 64'h1, 1'b1);
        send_block(8'h00, 1'b1);
        send_block(8'hFF, 1'b0);
        send_block(8'h55, 1'b0);
        send_block(8'hAA, 1'b0);
        drain();

        // Repeated S-box entries, all P-box sources at the last bit, zero key.
        configure(64'h0, 64'h1133_5577_99BB_DDFF, 64'hFFFFFF, 64'h00, 64'h0, 1'b0);
        send_block(8'hFF, 1'b1);
        send_block(8'h00, 1'b0);
        send_block(8'hF0, 1'b0);
        send_block(8'h0F, 1'b1);
        drain();

        // Random settings with CBC messages of random length.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            sbox = ($urandom_range(0, 99) < 80) ? shuffled_table(16, 4) : {$urandom, $urandom};
            pbox = ($urandom_range(0, 99) < 80) ? shuffled_table(8, 3) : {$urandom, $urandom};
            key  = {$urandom, $urandom};
            if (phase == 0) begin
                key[23:0] = '0;
            end else if (phase == RANDOM_PHASES - 1) begin
                key[23:0] = '1;
            end
            configure(key, sbox, {$urandom, $urandom} & ~64'hFFFFFF | pbox,
                      {$urandom, $urandom},
                      {$urandom, $urandom} & ~64'h1 | 64'(phase % 2),
                      $urandom_range(0, 2) == 0);

            steady_phase = ($urandom_range(0, 3) == 0);
            if (phase == 0 || phase == RANDOM_PHASES / 2) begin
                hold_requests++;
            end
            items    = $urandom_range(100, 160);
            msg_left = 0;
            for (int n = 0; n < items; n++) begin
                pick = $urandom_range(0, 99);
                if (msg_left == 0) begin
                    first    = 1'b1;
                    msg_left = $urandom_range(1, 24);
                end else begin
                    first = (pick < 5);
                end
                msg_left--;
                data = 8'($urandom_range(0, 255));
                if (pick >= 90 && pick < 95) begin
                    data = 8'h00;
                end else if (pick >= 95) begin
                    data = 8'hFF;
                end
                send_block(data, first);
            end
            drain();
        end
        steady_phase = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("toy_spn_block_cipher_cbc test passed");
        end else begin
            $display("toy_spn_block_cipher_cbc test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/toy_spn_pkg.sv
rtl/toy_spn_cfg.sv
rtl/toy_spn_core.sv
rtl/toy_spn_block_cipher_cbc.sv
rtl/toy_spn_chk.sv
sim/toy_spn_cbc_checker.sv
sim/tb_toy_spn_block_cipher_cbc.sv
